FILE: hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // What every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_ROTATE
    } cell_op_t;

    // Shared control that the sequencer broadcasts to the row
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } state_t;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_DELETE  = 2'd1;
    localparam logic [1:0] FUNC_DISPLAY = 2'd2;
    // Code three has no meaning; the block ignores it
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_LISTED    = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

endpackage

FILE: hw/rtl/spq_cell.sv
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic               occupied,
    input  logic               tail,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_data,
    input  spq_pkg::entry_t    right_data,
    input  spq_pkg::entry_t    head_data,
    output logic               keep,
    output spq_pkg::entry_t    data
);
    import spq_pkg::*;

    entry_t data_reg;
    entry_t data_next;

    // Stay put when the stored priority is not above the new one (ties keep arrival order)
    assign keep = occupied && (data_reg.prio <= ctrl.new_entry.prio);
    assign data = data_reg;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                if (keep)
                begin
                    data_next = data_reg;
                end
                else if (left_keep)
                begin
                    data_next = ctrl.new_entry;
                end
                else
                begin
                    data_next = left_data;
                end
            end
            CELL_SHIFT:
            begin
                data_next = right_data;
            end
            CELL_ROTATE:
            begin
                data_next = tail ? head_data : right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

FILE: hw/rtl/sorted_priority_queue.sv
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-------------------------------------------
// request   | in        | start, busy        | func, item_value, priority_req
// result    | out       | strobe (no stall)  | item_value_res, priority_res, status, last
//
// Insert and delete strobe their result in the cycle after the
// request, and a new request may follow right away (busy stays low).
// Display with N entries strobes N results in consecutive cycles, the first after
// the sequencer has entered its display state; busy is high in that state while the row
// rotates once front to back, so it drops as the final result strobes.
// Reset clears only the entry count, the sequencer and the result strobe; the receiver cannot stall.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]   priority_req,
    output logic                                strobe,
    output logic signed [spq_pkg::DATA_W-1:0]   item_value_res,
    output logic signed [spq_pkg::DATA_W-1:0]   priority_res,
    output logic [2:0]                          status,
    output logic                                last
);
    import spq_pkg::*;

    // Count must hold CAPACITY itself
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;

    logic                       strobe_reg, strobe_next;
    logic signed [DATA_W-1:0]   value_reg, value_next;
    logic signed [DATA_W-1:0]   prio_reg, prio_next;
    logic [2:0]                 status_reg, status_next;
    logic                       last_reg, last_next;

    cell_ctrl_t     ctrl;
    entry_t         cell_data [CAPACITY];
    logic           cell_keep [CAPACITY];
    entry_t         head;
    logic           accept;
    logic           is_full;
    logic           is_empty;
    logic           final_listed;

    assign accept       = start && !busy;
    assign head         = cell_data[0];
    assign is_full      = (count_reg == CAP_CNT);
    assign is_empty     = (count_reg == '0);
    assign final_listed = ((idx_reg + 1'b1) == count_reg);

    assign busy           = (state_reg == S_DISP);
    assign strobe         = strobe_reg;
    assign item_value_res = value_reg;
    assign priority_res   = prio_reg;
    assign status         = status_reg;
    assign last           = last_reg;

    // Row of sorted cells: cell 0 is the front of the queue
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CW-1:0] IDX      = CW'(gi);
            localparam logic [CW-1:0] IDX_NEXT = CW'(gi + 1);

            logic   occ;
            logic   tail;
            logic   lkeep;
            entry_t ldata;
            entry_t rdata;

            assign occ  = (IDX < count_reg);
            assign tail = (IDX_NEXT == count_reg);

            if (gi == 0)
            begin : g_first
                // Nothing ahead of the front cell: it is open to take the new entry
                assign lkeep = 1'b1;
                assign ldata = ctrl.new_entry;
            end
            else
            begin : g_mid
                assign lkeep = cell_keep[gi-1];
                assign ldata = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_end
                assign rdata = cell_data[gi];
            end
            else
            begin : g_inner
                assign rdata = cell_data[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occ),
                .tail       (tail),
                .left_keep  (lkeep),
                .left_data  (ldata),
                .right_data (rdata),
                .head_data  (head),
                .keep       (cell_keep[gi]),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Sequencer: decode the request, steer the row, load the result register
    always_comb
    begin
        state_next               = state_reg;
        count_next               = count_reg;
        idx_next                 = idx_reg;
        ctrl.op                  = CELL_HOLD;
        ctrl.new_entry.value     = item_value;
        ctrl.new_entry.prio      = priority_req;
        strobe_next              = 1'b0;
        value_next               = '0;
        prio_next                = '0;
        status_next              = ST_INSERTED;
        last_next                = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        FUNC_INSERT:
                        begin
                            strobe_next = 1'b1;
                            if (is_full)
                            begin
                                // Reject and leave the queue untouched
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = CELL_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            strobe_next = 1'b1;
                            if (is_empty)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                // Hand out the front entry and advance the row
                                ctrl.op     = CELL_SHIFT;
                                count_next  = count_reg - 1'b1;
                                value_next  = head.value;
                                prio_next   = head.prio;
                                status_next = ST_DELETED;
                            end
                        end
                        FUNC_DISPLAY:
                        begin
                            if (is_empty)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DISP;
                                idx_next   = '0;
                            end
                        end
                        default:
                        begin
                            // Unused code: drop the request without a result
                        end
                    endcase
                end
            end
            S_DISP:
            begin
                // Emit the front cell and rotate it to the tail; after count
                // steps the row is back in its original order
                ctrl.op     = CELL_ROTATE;
                strobe_next = 1'b1;
                value_next  = head.value;
                prio_next   = head.prio;
                status_next = ST_LISTED;
                last_next   = final_listed;
                if (final_listed)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

endmodule

FILE: hw/rtl/spq_checker.sv
module spq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  func,
    input logic        strobe,
    input logic [2:0]  status,
    input logic        last
);
    import spq_pkg::*;

    // Insert and delete answer in the very next cycle with a single result
    a_single_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (func == FUNC_INSERT || func == FUNC_DELETE)
        |=> strobe && last)
        else $error("insert/delete did not answer in the next cycle");

    // Every status other than a listed entry is a one-result answer
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status != ST_LISTED |-> last)
        else $error("single-result status without last");

    // A display stream ends exactly when busy drops
    a_stream_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last && status == ST_LISTED)
        else $error("busy dropped without final listed entry");

    // A listed entry that is not the final one keeps the block busy
    a_stream_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_LISTED && !last |-> busy)
        else $error("display stream while not busy");

    // The unused code produces no result
    a_unused_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func == FUNC_UNUSED |=> !strobe)
        else $error("result for unused request code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .func   (func),
    .strobe (strobe),
    .status (status),
    .last   (last)
);
